// ===== rtl/button_debounce_event_gen_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce event generator
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_EVENT_GEN_MACROS_SVH
`define BUTTON_DEBOUNCE_EVENT_GEN_MACROS_SVH

// property must hold at every edge outside reset
`define BDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define BDE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared constants and types of the button debounce event generator.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int NUM_BUTTONS       = 5;
    localparam int CPD_SHIFT         = 2;
    localparam int COUNTS_PER_DETENT = 1 << CPD_SHIFT;
    localparam int QUEUE_DEPTH       = 2;

    // event slots of one poll: slot 0 encoder, slot b+1 button b
    localparam int EVT_BITS  = NUM_BUTTONS + 1;
    localparam int EVT_IDX_W = $clog2(EVT_BITS);

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_BACK = 2'sb11;

    typedef struct packed {
        logic [EVT_BITS-1:0]    pending;
        logic signed [1:0]      enc_dir;
        logic [NUM_BUTTONS-1:0] held_old;
        logic [NUM_BUTTONS-1:0] stable_new;
    } poll_evt_t;

endpackage

// ===== rtl/bde_front.sv =====
// ----------------------------------------------------------------------------
// bde_front
// Takes polls, updates encoder and debounce state, queues the poll's events.
// ----------------------------------------------------------------------------
module bde_front
    import bde_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            time_ms,
    input  logic signed [31:0]     encoder_count,
    input  logic [NUM_BUTTONS-1:0] button_levels_n,
    output logic                   push,
    output poll_evt_t              push_data,
    input  logic                   q_full
);

    logic [15:0]            debounce_reg;
    logic signed [31:0]     detent_reg;
    logic [NUM_BUTTONS-1:0] prev_raw_reg;
    logic [NUM_BUTTONS-1:0] stable_reg;
    logic [31:0]            stamp_reg [NUM_BUTTONS];

    logic                   accept;
    logic signed [31:0]     enc_bias;
    logic signed [31:0]     enc_sum;
    logic signed [31:0]     detent_next;
    logic                   enc_ev;
    logic [NUM_BUTTONS-1:0] reading;
    logic [NUM_BUTTONS-1:0] btn_ev;
    logic [NUM_BUTTONS-1:0] stable_next;
    logic [31:0]            stamp_next [NUM_BUTTONS];
    logic [31:0]            elapsed    [NUM_BUTTONS];

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // truncate toward zero: bias negative counts before the arithmetic shift
    assign enc_bias    = encoder_count[31] ? 32'(COUNTS_PER_DETENT - 1) : 32'sd0;
    assign enc_sum     = encoder_count + enc_bias;
    assign detent_next = enc_sum >>> CPD_SHIFT;
    assign enc_ev      = detent_next != detent_reg;

    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            reading[b]     = ~button_levels_n[b];
            stamp_next[b]  = (reading[b] != prev_raw_reg[b]) ? time_ms : stamp_reg[b];
            elapsed[b]     = time_ms - stamp_next[b];
            btn_ev[b]      = (elapsed[b] > {16'd0, debounce_reg}) &&
                             (reading[b] != stable_reg[b]);
            stable_next[b] = btn_ev[b] ? reading[b] : stable_reg[b];
        end
    end

    assign push                 = accept && (enc_ev || (|btn_ev));
    assign push_data.pending    = {btn_ev, enc_ev};
    assign push_data.enc_dir    = (detent_next > detent_reg) ? DIR_FWD : DIR_BACK;
    assign push_data.held_old   = stable_reg;
    assign push_data.stable_new = stable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            detent_reg   <= '0;
            prev_raw_reg <= '0;
            stable_reg   <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                stamp_reg[b] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                debounce_reg <= cfg_wdata;
            end
            if (accept)
            begin
                detent_reg   <= detent_next;
                prev_raw_reg <= reading;
                stable_reg   <= stable_next;
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    stamp_reg[b] <= stamp_next[b];
                end
            end
        end
    end

endmodule

// ===== rtl/bde_fifo.sv =====
// ----------------------------------------------------------------------------
// bde_fifo
// Short queue of per-poll event sets between front and back.
// ----------------------------------------------------------------------------
module bde_fifo
    import bde_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  poll_evt_t push_data,
    output logic      full,
    input  logic      pop,
    output poll_evt_t pop_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    poll_evt_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/bde_back.sv =====
// ----------------------------------------------------------------------------
// bde_back
// Serializes a poll's event set into one event per cycle on the output while out_ready is high.
// ----------------------------------------------------------------------------
module bde_back
    import bde_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  poll_evt_t              q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             event_source,
    output logic                   pressed,
    output logic signed [1:0]      direction,
    output logic [NUM_BUTTONS-1:0] held_mask,
    output logic                   last_of_poll
);

`include "button_debounce_event_gen_macros.svh"

    logic [EVT_BITS-1:0]    pending_reg;
    logic [EVT_BITS-1:0]    pending_next;
    logic signed [1:0]      enc_dir_reg;
    logic [NUM_BUTTONS-1:0] held_old_reg;
    logic [NUM_BUTTONS-1:0] stable_new_reg;

    logic                   out_valid_reg;
    logic [2:0]             source_reg;
    logic                   pressed_reg;
    logic signed [1:0]      dir_reg;
    logic [NUM_BUTTONS-1:0] held_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   fire;
    logic [EVT_IDX_W-1:0]   idx;
    logic [EVT_BITS-1:0]    remaining;
    logic [NUM_BUTTONS-1:0] le_mask;
    logic [NUM_BUTTONS-1:0] held_at;
    logic                   pressed_at;

    // lowest pending slot goes first: encoder, then buttons in order
    always_comb
    begin
        idx = '0;
        for (int i = EVT_BITS - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                idx = EVT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        remaining  = pending_reg;
        pressed_at = 1'b0;
        for (int i = 0; i < EVT_BITS; i++)
        begin
            if (idx == EVT_IDX_W'(i))
            begin
                remaining[i] = 1'b0;
            end
        end
        // buttons up to the current one already carry their new level
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            le_mask[i] = EVT_IDX_W'(i) < idx;
            if (idx == EVT_IDX_W'(i + 1))
            begin
                pressed_at = stable_new_reg[i];
            end
        end
        held_at = (stable_new_reg & le_mask) | (held_old_reg & ~le_mask);
    end

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = (|pending_reg) && out_free;
    assign pop      = !q_empty && (!(|pending_reg) || (fire && !(|remaining)));

    always_comb
    begin
        pending_next = pending_reg;
        if (pop)
        begin
            pending_next = q_data.pending;
        end
        else if (fire)
        begin
            pending_next = remaining;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            enc_dir_reg    <= q_data.enc_dir;
            held_old_reg   <= q_data.held_old;
            stable_new_reg <= q_data.stable_new;
        end
        if (fire)
        begin
            source_reg  <= 3'(idx);
            pressed_reg <= pressed_at;
            dir_reg     <= (idx == '0) ? enc_dir_reg : DIR_NONE;
            held_reg    <= held_at;
            last_reg    <= !(|remaining);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_source = source_reg;
    assign pressed      = pressed_reg;
    assign direction    = dir_reg;
    assign held_mask    = held_reg;
    assign last_of_poll = last_reg;

    `BDE_ASSERT(a_enc_has_dir, out_valid && event_source == 3'd0 |-> direction != DIR_NONE, "encoder event without direction")
    `BDE_ASSERT(a_btn_no_dir, out_valid && event_source != 3'd0 |-> direction == DIR_NONE && event_source <= 3'(NUM_BUTTONS), "bad button event")
    `BDE_ASSERT(a_poll_no_gap, out_valid && out_ready && !last_of_poll |=> out_valid, "gap inside a poll's events")
    `BDE_NEVER(a_enc_pressed, out_valid && event_source == 3'd0 && pressed, "encoder event marked pressed")

endmodule

// ===== rtl/button_debounce_event_gen.sv =====
// ----------------------------------------------------------------------------
// button_debounce_event_gen
// Encoder detent tracking and button debounce with a serialized event output.
//
//   channel | signals                                     | handshake
//   --------+---------------------------------------------+------------------
//   poll in | time_ms, encoder_count, button_levels_n     | in_valid/in_ready
//   event   | event_source, pressed, direction, held_mask,| out_valid/out_ready
//           | last_of_poll                                |
//   config  | cfg_wdata (debounce_ms)                     | cfg_we, no wait
//
// A poll is classified in the cycle it is accepted; polls with events queue
// their event set (FIFO_DEPTH entries). The back end emits one event a cycle
// while out_ready is high; quiet polls are not queued.
// Event throughput is limited by out_ready and by the arrival of polls.
// Reset clears all but the data registers at once; no clearing pass.
// in_ready drops only while the event queue is full.
// ----------------------------------------------------------------------------
module button_debounce_event_gen
    import bde_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            time_ms,
    input  logic signed [31:0]     encoder_count,
    input  logic [4:0]             button_levels_n,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             event_source,
    output logic                   pressed,
    output logic signed [1:0]      direction,
    output logic [4:0]             held_mask,
    output logic                   last_of_poll
);

    logic      push;
    poll_evt_t push_data;
    logic      q_full;
    logic      pop;
    poll_evt_t pop_data;
    logic      q_empty;

    bde_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .time_ms         (time_ms),
        .encoder_count   (encoder_count),
        .button_levels_n (button_levels_n),
        .push            (push),
        .push_data       (push_data),
        .q_full          (q_full)
    );

    bde_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    bde_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_source (event_source),
        .pressed      (pressed),
        .direction    (direction),
        .held_mask    (held_mask),
        .last_of_poll (last_of_poll)
    );

endmodule
